// File: hw/rtl/drac_pkg.sv
// package for the deny address recency cache
// types, widths and codes shared by the top level and drac_ctrl
`timescale 1ns / 1ps

package drac_pkg;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CW        = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CAP_W     = 9;
  localparam int unsigned THR_W     = 8;
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned CAP_CMP_W = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned POS_CMP_W = (AW > THR_W) ? AW : THR_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CAP_W-1:0] CAPACITY_RESET  = CAP_W'(200);
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
  } in_word_t;

  typedef struct packed {
    logic                 found;
    logic [CNT_OUT_W-1:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic [THR_W-1:0] reorder_threshold;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [ADDR_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } ram_req_t;

endpackage

// File: hw/rtl/deny_address_recency_cache.sv
// top level of the deny address recency cache
// depends on drac_pkg, drac_ram and drac_ctrl
`timescale 1ns / 1ps

// usage:
//   in channel (in_valid_i / in_ready_o / in_word_i) takes one word at a time:
//   opcode 0 looks an address up, opcode 1 inserts it. in_ready_o is high
//   only while no word is in work.
//   out channel (out_valid_o / out_ready_i / out_word_o) gives one word per
//   input word: found flag and entries held afterwards.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) writes
//   capacity (index 0) or reorder threshold (index 1); always ready. the user
//   must write it only while the block is idle; the block does not enforce it.
// operation:
//   a scan reads the held list through the single ram read port and stops
//   early on a hit. a move to front or an insert of a new address adds a
//   shift pass over entries 0 to k, one ram read and write per cycle, k being
//   the hit position or entries kept. the output register is then loaded.
//   reset empties the list and restores capacity 200, threshold 100; there
//   is no clearing pass. a stalled receiver holds the result in the output
//   register and the next word is taken; its result waits until the slot frees.

module deny_address_recency_cache (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  drac_pkg::in_word_t               in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output drac_pkg::out_word_t              out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [drac_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [drac_pkg::CAP_W-1:0]       cfg_data_i
);
  import drac_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;
  logic      res_valid;
  logic      res_ready;
  out_word_t res_word;
  ram_req_t  ram_req;
  logic [ADDR_W-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CAPACITY:  cfg_d.capacity          = cfg_data_i;
        CFG_THRESHOLD: cfg_d.reorder_threshold = cfg_data_i[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_word_d  = res_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity          <= CAPACITY_RESET;
      cfg_q.reorder_threshold <= THRESHOLD_RESET;
      out_valid_q             <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  drac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_word_o  (res_word),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  drac_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: hw/rtl/drac_ram.sv
// generic single write, single read synchronous ram, read-first
// standalone, no package dependency
`timescale 1ns / 1ps

module drac_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/drac_ctrl.sv
// sequencer: scans the ram list, then shifts down for move to front or insert
// depends on drac_pkg
`timescale 1ns / 1ps

module drac_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drac_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  drac_pkg::in_word_t in_word_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output drac_pkg::out_word_t res_word_o,
  output drac_pkg::ram_req_t ram_req_o,
  input  logic [drac_pkg::ADDR_W-1:0] ram_rdata_i
);
  import drac_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     held_q, held_d;
  logic [CW-1:0]     ridx_q, ridx_d;
  logic              cmp_v_q, cmp_v_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]     sidx_q, sidx_d;
  logic [AW-1:0]     k_q, k_d;
  logic              found_q, found_d;
  logic              grow_q, grow_d;
  in_word_t          item_q, item_d;

  logic [CAP_CMP_W-1:0] cap_w;
  logic [CW-1:0]        eff_cap;
  logic [CW-1:0]        cap_m1;
  logic [CW-1:0]        keep;
  logic                 hit_now;
  logic                 move_front;

  always_comb begin
    cap_w = CAP_CMP_W'(cfg_i.capacity);
    if (cap_w == '0) begin
      eff_cap = CW'(1);
    end else if (cap_w > CAP_CMP_W'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_w);
    end
    cap_m1 = eff_cap - CW'(1);
    keep   = (held_q > cap_m1) ? cap_m1 : held_q;
  end

  assign hit_now    = cmp_v_q && (ram_rdata_i == item_q.address);
  assign move_front = POS_CMP_W'(cmp_idx_q) > POS_CMP_W'(cfg_i.reorder_threshold);

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    ridx_d    = ridx_q;
    cmp_v_d   = 1'b0;
    cmp_idx_d = cmp_idx_q;
    sidx_d    = sidx_q;
    k_d       = k_q;
    found_d   = found_q;
    grow_d    = grow_q;
    item_d    = item_q;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = sidx_q;
    ram_req_o.wdata = (sidx_q == '0) ? item_q.address : ram_rdata_i;
    ram_req_o.raddr = ridx_q[AW-1:0];
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_word_i;
          ridx_d  = '0;
          found_d = 1'b0;
          grow_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          found_d = 1'b1;
          k_d     = cmp_idx_q;
          sidx_d  = '0;
          if (item_q.opcode == OP_LOOKUP && move_front) begin
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_FIN;
          end
        end else if (ridx_q < held_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = ridx_q[AW-1:0];
          ridx_d    = ridx_q + CW'(1);
        end else if (!cmp_v_q) begin
          sidx_d = '0;
          k_d    = keep[AW-1:0];
          if (item_q.opcode == OP_INSERT) begin
            grow_d  = 1'b1;
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SHIFT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.raddr = sidx_q;
        if (sidx_q == k_q) begin
          if (grow_q) begin
            held_d = CW'(k_q) + CW'(1);
          end
          state_d = ST_FIN;
        end else begin
          sidx_d = sidx_q + AW'(1);
        end
      end
      ST_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_word_o.found       = found_q;
  assign res_word_o.entry_count = CNT_OUT_W'(held_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= '0;
      cmp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      cmp_v_q <= cmp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q    <= ridx_d;
    cmp_idx_q <= cmp_idx_d;
    sidx_q    <= sidx_d;
    k_q       <= k_d;
    found_q   <= found_d;
    grow_q    <= grow_d;
    item_q    <= item_d;
  end

  // held count never grows past the ram depth
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(DEPTH))
    else $error("held count above depth");

  // an accepted word always starts a scan
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCAN))
    else $error("accepted word did not start a scan");

  // held count only changes at the end of a shift pass
  a_held_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != $past(held_q)) |-> ($past(state_q) == ST_SHIFT))
    else $error("held count changed outside a shift");

  // shift writes stay inside the held list plus the new slot
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (CW'(sidx_q) <= held_q))
    else $error("shift write beyond held entries");

endmodule
